// File: design/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants for the romaji to hiragana tail block
// Holds the result beat layout, the fixed kana code points and the helper
// functions that fold ASCII letters and pick palatal base kana.
// ----------------------------------------------------------------------------
package rth_pkg;

   localparam int unsigned CHAR_W  = 21;
   localparam int unsigned KANA_W  = 16;
   localparam int unsigned COUNT_W = 2;

   localparam logic [KANA_W-1:0] KANA_NONE      = 16'd0;
   localparam logic [KANA_W-1:0] KANA_SMALL_YA  = 16'd12419;
   localparam logic [KANA_W-1:0] KANA_SMALL_YU  = 16'd12421;
   localparam logic [KANA_W-1:0] KANA_SMALL_YO  = 16'd12423;
   localparam logic [KANA_W-1:0] KANA_SYL_N     = 16'd12435;
   localparam logic [KANA_W-1:0] KANA_SMALL_TSU = 16'd12387;
   localparam logic [KANA_W-1:0] KANA_SHI       = 16'd12375;
   localparam logic [KANA_W-1:0] KANA_CHI       = 16'd12385;
   localparam logic [KANA_W-1:0] KANA_JI        = 16'd12376;
   localparam logic [KANA_W-1:0] MARK_COMMA     = 16'd12289;
   localparam logic [KANA_W-1:0] MARK_STOP      = 16'd12290;
   localparam logic [KANA_W-1:0] MARK_SPACE     = 16'd12288;
   localparam logic [KANA_W-1:0] MARK_YEN       = 16'd165;
   localparam logic [KANA_W-1:0] MARK_LONG      = 16'd12540;
   localparam logic [KANA_W-1:0] MARK_WAVE      = 16'd12316;
   localparam logic [KANA_W-1:0] MARK_LBRACKET  = 16'd12304;
   localparam logic [KANA_W-1:0] MARK_RBRACKET  = 16'd12305;

   localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [KANA_W-1:0]  second;
      logic [KANA_W-1:0]  first;
   } kana_type;

   // Lowercase ASCII code of a code point; anything outside ASCII folds to zero.
   function automatic logic [7:0] lower_ascii(input logic [CHAR_W-1:0] c);
      logic [7:0] code;
      code = {1'b0, c[6:0]};
      if (c[CHAR_W-1:7] != '0) begin
         return 8'd0;
      end else if (code >= "A" && code <= "Z") begin
         return code + 8'd32;
      end
      return code;
   endfunction

   function automatic logic is_vowel(input logic [7:0] l);
      return (l == "a") || (l == "i") || (l == "u") || (l == "e") || (l == "o");
   endfunction

   // i-row kana that takes a small ya/yu/yo, zero when the letter has none.
   function automatic logic [KANA_W-1:0] palatal_base(input logic [7:0] l);
      logic [KANA_W-1:0] k;
      unique case (l)
         "k":     k = 16'd12365;
         "n":     k = 16'd12395;
         "h":     k = 16'd12402;
         "m":     k = 16'd12415;
         "r":     k = 16'd12426;
         "g":     k = 16'd12366;
         "b":     k = 16'd12403;
         "p":     k = 16'd12404;
         default: k = KANA_NONE;
      endcase
      return k;
   endfunction

endpackage

// File: design/rth_vowel.sv
// ----------------------------------------------------------------------------
// rth_vowel: kana for a vowel and the letters before it
// Resolves palatal, h-row, j and plain consonant rows for one vowel given the
// two preceding lowercase letters.
// ----------------------------------------------------------------------------
module rth_vowel (
   input  logic [7:0]       vowel,
   input  logic [7:0]       l2,
   input  logic [7:0]       l3,
   output rth_pkg::kana_type kana
);

   logic [rth_pkg::KANA_W-1:0] small_kana;
   logic [rth_pkg::KANA_W-1:0] pal_base;
   logic [rth_pkg::KANA_W-1:0] row_kana;
   logic                       pal;

   assign small_kana = (vowel == "a") ? rth_pkg::KANA_SMALL_YA :
                       (vowel == "u") ? rth_pkg::KANA_SMALL_YU : rth_pkg::KANA_SMALL_YO;
   assign pal      = (vowel == "a") || (vowel == "u") || (vowel == "o");
   assign pal_base = rth_pkg::palatal_base(l3);

   always_comb begin
      unique case (vowel)
         "a": begin
            unique case (l2)
               "s":     row_kana = 16'd12373;
               "k":     row_kana = 16'd12363;
               "t":     row_kana = 16'd12383;
               "n":     row_kana = 16'd12394;
               "m":     row_kana = 16'd12414;
               "r":     row_kana = 16'd12425;
               "w":     row_kana = 16'd12431;
               "g":     row_kana = 16'd12364;
               "z":     row_kana = 16'd12374;
               "d":     row_kana = 16'd12384;
               "b":     row_kana = 16'd12400;
               "p":     row_kana = 16'd12401;
               default: row_kana = 16'd12354;
            endcase
         end
         "i": begin
            unique case (l2)
               "k":     row_kana = 16'd12365;
               "n":     row_kana = 16'd12395;
               "m":     row_kana = 16'd12415;
               "r":     row_kana = 16'd12426;
               "g":     row_kana = 16'd12366;
               "z":     row_kana = 16'd12376;
               "d":     row_kana = 16'd12376;
               "j":     row_kana = 16'd12376;
               "b":     row_kana = 16'd12403;
               "p":     row_kana = 16'd12404;
               default: row_kana = 16'd12356;
            endcase
         end
         "u": begin
            unique case (l2)
               "s":     row_kana = (l3 == "t") ? 16'd12388 : 16'd12377;
               "k":     row_kana = 16'd12367;
               "n":     row_kana = 16'd12396;
               "m":     row_kana = 16'd12416;
               "r":     row_kana = 16'd12427;
               "g":     row_kana = 16'd12368;
               "z":     row_kana = 16'd12378;
               "d":     row_kana = 16'd12378;
               "b":     row_kana = 16'd12406;
               "p":     row_kana = 16'd12407;
               "v":     row_kana = 16'd12436;
               default: row_kana = 16'd12358;
            endcase
         end
         "e": begin
            unique case (l2)
               "h":     row_kana = 16'd12408;
               "s":     row_kana = 16'd12379;
               "k":     row_kana = 16'd12369;
               "t":     row_kana = 16'd12390;
               "n":     row_kana = 16'd12397;
               "m":     row_kana = 16'd12417;
               "r":     row_kana = 16'd12428;
               "g":     row_kana = 16'd12370;
               "z":     row_kana = 16'd12380;
               "d":     row_kana = 16'd12391;
               "b":     row_kana = 16'd12409;
               "p":     row_kana = 16'd12410;
               default: row_kana = 16'd12360;
            endcase
         end
         default: begin
            unique case (l2)
               "s":     row_kana = 16'd12381;
               "k":     row_kana = 16'd12371;
               "t":     row_kana = 16'd12392;
               "n":     row_kana = 16'd12398;
               "m":     row_kana = 16'd12418;
               "r":     row_kana = 16'd12429;
               "w":     row_kana = 16'd12434;
               "g":     row_kana = 16'd12372;
               "z":     row_kana = 16'd12382;
               "d":     row_kana = 16'd12393;
               "b":     row_kana = 16'd12412;
               "p":     row_kana = 16'd12413;
               default: row_kana = 16'd12362;
            endcase
         end
      endcase
   end

   always_comb begin
      kana.first  = row_kana;
      kana.second = rth_pkg::KANA_NONE;
      kana.count  = rth_pkg::COUNT_ONE;
      priority if (pal && l2 == "y") begin
         if (pal_base != rth_pkg::KANA_NONE) begin
            kana.first  = pal_base;
            kana.second = small_kana;
            kana.count  = rth_pkg::COUNT_TWO;
         end else begin
            kana.first = (vowel == "a") ? 16'd12420 :
                         (vowel == "u") ? 16'd12422 : 16'd12424;
         end
      end else if (l2 == "h" || (vowel == "u" && l2 == "f")) begin
         if (vowel != "e" && (l3 == "s" || l3 == "c")) begin
            kana.first = (l3 == "s") ? rth_pkg::KANA_SHI : rth_pkg::KANA_CHI;
            if (vowel != "i") begin
               kana.second = small_kana;
               kana.count  = rth_pkg::COUNT_TWO;
            end
         end else begin
            kana.first = (vowel == "a") ? 16'd12399 :
                         (vowel == "i") ? 16'd12402 :
                         (vowel == "u") ? 16'd12405 :
                         (vowel == "e") ? 16'd12408 : 16'd12411;
         end
      end else if (pal && l2 == "j") begin
         kana.first  = rth_pkg::KANA_JI;
         kana.second = small_kana;
         kana.count  = rth_pkg::COUNT_TWO;
      end else begin
         kana.first = row_kana;
      end
   end

endmodule

// File: design/rth_decode.sv
// ----------------------------------------------------------------------------
// rth_decode: kana for the text ending at the newest character
// Combines the vowel path with the syllabic n, punctuation, small tsu and
// symbol pass-through rules, in priority order.
// ----------------------------------------------------------------------------
module rth_decode (
   input  logic [rth_pkg::CHAR_W-1:0] c1,
   input  logic [rth_pkg::CHAR_W-1:0] c2,
   input  logic [rth_pkg::CHAR_W-1:0] c3,
   output rth_pkg::kana_type          kana
);

   logic [7:0]        l1;
   logic [7:0]        l2;
   logic [7:0]        l3;
   logic              tsu_letter;
   logic              pass_symbol;
   rth_pkg::kana_type vowel_kana;

   assign l1 = rth_pkg::lower_ascii(c1);
   assign l2 = rth_pkg::lower_ascii(c2);
   assign l3 = rth_pkg::lower_ascii(c3);

   assign tsu_letter  = (c1 > 21'd65 && c1 < 21'd91) || (c1 > 21'd97 && c1 < 21'd123);
   assign pass_symbol = (c1 > 21'd32 && c1 < 21'd65) || (c1 > 21'd90 && c1 < 21'd96) ||
                        (c1 > 21'd122 && c1 < 21'd126);

   rth_vowel u_vowel (
      .vowel (l1),
      .l2    (l2),
      .l3    (l3),
      .kana  (vowel_kana)
   );

   always_comb begin
      kana.first  = rth_pkg::KANA_NONE;
      kana.second = rth_pkg::KANA_NONE;
      kana.count  = rth_pkg::COUNT_ONE;
      priority if (rth_pkg::is_vowel(l1)) begin
         kana = vowel_kana;
      end else if (l1 != "y" && l2 == "n") begin
         kana.first = rth_pkg::KANA_SYL_N;
      end else if (c1 == 21'd44) begin
         kana.first = rth_pkg::MARK_COMMA;
      end else if (c1 == 21'd46) begin
         kana.first = rth_pkg::MARK_STOP;
      end else if (c1 == 21'd32) begin
         kana.first = rth_pkg::MARK_SPACE;
      end else if (c1 == 21'd36) begin
         kana.first = rth_pkg::MARK_YEN;
      end else if (c1 == 21'd45) begin
         kana.first = rth_pkg::MARK_LONG;
      end else if (c1 == 21'd126) begin
         kana.first = rth_pkg::MARK_WAVE;
      end else if (c1 == 21'd40) begin
         kana.first = rth_pkg::MARK_LBRACKET;
      end else if (c1 == 21'd41) begin
         kana.first = rth_pkg::MARK_RBRACKET;
      end else if (c1 == c2 && tsu_letter) begin
         kana.first = rth_pkg::KANA_SMALL_TSU;
      end else if (pass_symbol) begin
         kana.first = c1[rth_pkg::KANA_W-1:0];
      end else begin
         kana.count = rth_pkg::COUNT_NONE;
      end
   end

endmodule

// File: design/romaji_to_hiragana_tail.sv
// ----------------------------------------------------------------------------
// romaji_to_hiragana_tail: streaming romaji to hiragana transliterator
// Takes one code point per beat, keeps the two before it and returns the
// hiragana for the text that ends at each character.
//
//   Channel | Dir | Beat contents
//   req_*   | in  | tdata: char_in[20:0]; tuser: start_of_text
//   rsp_*   | out | tdata: kana_first, kana_second, kana_count
//
// One beat in and one beat out per cycle while rsp_tready holds; each beat
// passes an input register and a result register around one decode pass.
// The history advances when a beat moves from the input to the result register.
// Reset clears both valid flags and the history to the absent character.
// A stalled result holds the input register, and req_tready falls with it.
// ----------------------------------------------------------------------------
module romaji_to_hiragana_tail (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] char_in, [23:21] zero
   input  logic [0:0]  req_tuser,   // [0] start_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [15:0] kana_first, [31:16] kana_second,
                                    // [33:32] kana_count, [39:34] zero
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [rth_pkg::CHAR_W-1:0] in_char_ff;
   logic                       in_start_ff;
   logic [rth_pkg::CHAR_W-1:0] prev_ff;
   logic [rth_pkg::CHAR_W-1:0] prev_in;
   logic [rth_pkg::CHAR_W-1:0] prev2_ff;
   logic [rth_pkg::CHAR_W-1:0] prev2_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   rth_pkg::kana_type          out_kana_ff;
   rth_pkg::kana_type          kana;
   logic [rth_pkg::CHAR_W-1:0] c2;
   logic [rth_pkg::CHAR_W-1:0] c3;
   logic                       req_take;
   logic                       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign c2 = in_start_ff ? '0 : prev_ff;
   assign c3 = in_start_ff ? '0 : prev2_ff;

   rth_decode u_decode (
      .c1   (in_char_ff),
      .c2   (c2),
      .c3   (c3),
      .kana (kana)
   );

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign prev_in      = advance ? in_char_ff : prev_ff;
   assign prev2_in     = advance ? c2 : prev2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
         prev2_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         prev_ff      <= prev_in;
         prev2_ff     <= prev2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff  <= req_tdata[rth_pkg::CHAR_W-1:0];
         in_start_ff <= req_tuser[0];
      end
      if (advance) begin
         out_kana_ff <= kana;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_kana_ff.count, out_kana_ff.second, out_kana_ff.first};

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("decoded beat did not reach the result register");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_kana_ff.count == rth_pkg::COUNT_NONE) |->
      (out_kana_ff.first == rth_pkg::KANA_NONE && out_kana_ff.second == rth_pkg::KANA_NONE))
      else $error("empty result carries a code point");

   a_single_no_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_kana_ff.count == rth_pkg::COUNT_ONE) |->
      out_kana_ff.second == rth_pkg::KANA_NONE)
      else $error("single kana result carries a second code point");

   a_pair_small: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_kana_ff.count == rth_pkg::COUNT_TWO) |->
      (out_kana_ff.second == rth_pkg::KANA_SMALL_YA ||
       out_kana_ff.second == rth_pkg::KANA_SMALL_YU ||
       out_kana_ff.second == rth_pkg::KANA_SMALL_YO))
      else $error("pair result without small ya/yu/yo");

   a_history_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(prev_ff) && $stable(prev2_ff)))
      else $error("history moved without a decoded beat");

endmodule

// File: tb/romaji_to_hiragana_tail_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// romaji_to_hiragana_tail_checker: result predictor and scoreboard
// Watches both streams of the transliterator. Each accepted request beat is
// run through a local model of the romaji decoder, which keeps its own copy
// of the two-character history. Each response beat is then compared field
// by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module romaji_to_hiragana_tail_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count,
   output int          pair_count,
   output int          empty_count
);

   logic [rth_pkg::CHAR_W-1:0] last_char;
   logic [rth_pkg::CHAR_W-1:0] older_char;
   rth_pkg::kana_type          expected_kana[$];
   int                         fails;
   int                         results;
   int                         pairs;
   int                         empties;

   function automatic logic [rth_pkg::CHAR_W-1:0] fold_letter(
      input logic [rth_pkg::CHAR_W-1:0] c);
      return (c >= 21'd65 && c <= 21'd90) ? c + 21'd32 : c;
   endfunction

   function automatic rth_pkg::kana_type predict_kana(input logic [rth_pkg::CHAR_W-1:0] c1,
                                                      input logic [rth_pkg::CHAR_W-1:0] c2,
                                                      input logic [rth_pkg::CHAR_W-1:0] c3);
      rth_pkg::kana_type          k;
      logic [rth_pkg::CHAR_W-1:0] l1;
      logic [rth_pkg::CHAR_W-1:0] l2;
      logic [rth_pkg::CHAR_W-1:0] l3;
      logic [rth_pkg::KANA_W-1:0] small_kana;
      logic                       palatal;
      k = '0;
      l1 = fold_letter(c1);
      l2 = fold_letter(c2);
      l3 = fold_letter(c3);
      small_kana = (l1 == "a") ? rth_pkg::KANA_SMALL_YA :
                   (l1 == "u") ? rth_pkg::KANA_SMALL_YU : rth_pkg::KANA_SMALL_YO;
      palatal = (l1 == "a") || (l1 == "u") || (l1 == "o");
      if (l1 == "a" || l1 == "i" || l1 == "u" || l1 == "e" || l1 == "o") begin
         k.count = rth_pkg::COUNT_ONE;
         if (palatal && l2 == "y") begin
            case (l3)
               "k":     k.first = 16'd12365;
               "n":     k.first = 16'd12395;
               "h":     k.first = 16'd12402;
               "m":     k.first = 16'd12415;
               "r":     k.first = 16'd12426;
               "g":     k.first = 16'd12366;
               "b":     k.first = 16'd12403;
               "p":     k.first = 16'd12404;
               default: k.first = rth_pkg::KANA_NONE;
            endcase
            if (k.first != rth_pkg::KANA_NONE) begin
               k.second = small_kana;
               k.count = rth_pkg::COUNT_TWO;
            end else begin
               k.first = (l1 == "a") ? 16'd12420 : (l1 == "u") ? 16'd12422 : 16'd12424;
            end
         end else if (l2 == "h" || (l1 == "u" && l2 == "f")) begin
            if (l1 != "e" && (l3 == "s" || l3 == "c")) begin
               k.first = (l3 == "s") ? rth_pkg::KANA_SHI : rth_pkg::KANA_CHI;
               if (l1 != "i") begin
                  k.second = small_kana;
                  k.count = rth_pkg::COUNT_TWO;
               end
            end else begin
               case (l1)
                  "a":     k.first = 16'd12399;
                  "i":     k.first = 16'd12402;
                  "u":     k.first = 16'd12405;
                  "e":     k.first = 16'd12408;
                  default: k.first = 16'd12411;
               endcase
            end
         end else if (palatal && l2 == "j") begin
            k.first = rth_pkg::KANA_JI;
            k.second = small_kana;
            k.count = rth_pkg::COUNT_TWO;
         end else begin
            case (l1)
               "a": begin
                  case (l2)
                     "s":     k.first = 16'd12373;
                     "k":     k.first = 16'd12363;
                     "t":     k.first = 16'd12383;
                     "n":     k.first = 16'd12394;
                     "m":     k.first = 16'd12414;
                     "r":     k.first = 16'd12425;
                     "w":     k.first = 16'd12431;
                     "g":     k.first = 16'd12364;
                     "z":     k.first = 16'd12374;
                     "d":     k.first = 16'd12384;
                     "b":     k.first = 16'd12400;
                     "p":     k.first = 16'd12401;
                     default: k.first = 16'd12354;
                  endcase
               end
               "i": begin
                  case (l2)
                     "k":     k.first = 16'd12365;
                     "n":     k.first = 16'd12395;
                     "m":     k.first = 16'd12415;
                     "r":     k.first = 16'd12426;
                     "g":     k.first = 16'd12366;
                     "z":     k.first = 16'd12376;
                     "d":     k.first = 16'd12376;
                     "j":     k.first = 16'd12376;
                     "b":     k.first = 16'd12403;
                     "p":     k.first = 16'd12404;
                     default: k.first = 16'd12356;
                  endcase
               end
               "u": begin
                  case (l2)
                     "s":     k.first = (l3 == "t") ? 16'd12388 : 16'd12377;
                     "k":     k.first = 16'd12367;
                     "n":     k.first = 16'd12396;
                     "m":     k.first = 16'd12416;
                     "r":     k.first = 16'd12427;
                     "g":     k.first = 16'd12368;
                     "z":     k.first = 16'd12378;
                     "d":     k.first = 16'd12378;
                     "b":     k.first = 16'd12406;
                     "p":     k.first = 16'd12407;
                     "v":     k.first = 16'd12436;
                     default: k.first = 16'd12358;
                  endcase
               end
               "e": begin
                  case (l2)
                     "h":     k.first = 16'd12408;
                     "s":     k.first = 16'd12379;
                     "k":     k.first = 16'd12369;
                     "t":     k.first = 16'd12390;
                     "n":     k.first = 16'd12397;
                     "m":     k.first = 16'd12417;
                     "r":     k.first = 16'd12428;
                     "g":     k.first = 16'd12370;
                     "z":     k.first = 16'd12380;
                     "d":     k.first = 16'd12391;
                     "b":     k.first = 16'd12409;
                     "p":     k.first = 16'd12410;
                     default: k.first = 16'd12360;
                  endcase
               end
               default: begin
                  case (l2)
                     "s":     k.first = 16'd12381;
                     "k":     k.first = 16'd12371;
                     "t":     k.first = 16'd12392;
                     "n":     k.first = 16'd12398;
                     "m":     k.first = 16'd12418;
                     "r":     k.first = 16'd12429;
                     "w":     k.first = 16'd12434;
                     "g":     k.first = 16'd12372;
                     "z":     k.first = 16'd12382;
                     "d":     k.first = 16'd12393;
                     "b":     k.first = 16'd12412;
                     "p":     k.first = 16'd12413;
                     default: k.first = 16'd12362;
                  endcase
               end
            endcase
         end
      end else if (l1 != "y" && l2 == "n") begin
         k.first = rth_pkg::KANA_SYL_N;
         k.count = rth_pkg::COUNT_ONE;
      end else begin
         k.count = rth_pkg::COUNT_ONE;
         case (c1)
            ",":     k.first = rth_pkg::MARK_COMMA;
            ".":     k.first = rth_pkg::MARK_STOP;
            " ":     k.first = rth_pkg::MARK_SPACE;
            "$":     k.first = rth_pkg::MARK_YEN;
            "-":     k.first = rth_pkg::MARK_LONG;
            "~":     k.first = rth_pkg::MARK_WAVE;
            "(":     k.first = rth_pkg::MARK_LBRACKET;
            ")":     k.first = rth_pkg::MARK_RBRACKET;
            default: begin
               if (c1 == c2 && ((c1 > 21'd65 && c1 < 21'd91) ||
                                (c1 > 21'd97 && c1 < 21'd123))) begin
                  k.first = rth_pkg::KANA_SMALL_TSU;
               end else if ((c1 > 21'd32 && c1 < 21'd65) || (c1 > 21'd90 && c1 < 21'd96) ||
                            (c1 > 21'd122 && c1 < 21'd126)) begin
                  k.first = c1[rth_pkg::KANA_W-1:0];
               end else begin
                  k.count = rth_pkg::COUNT_NONE;
               end
            end
         endcase
      end
      return k;
   endfunction

   always @(posedge clock) begin
      rth_pkg::kana_type          want;
      rth_pkg::kana_type          got;
      logic [rth_pkg::CHAR_W-1:0] ch;
      logic [rth_pkg::CHAR_W-1:0] prior;
      logic [rth_pkg::CHAR_W-1:0] prior2;
      if (reset) begin
         last_char = '0;
         older_char = '0;
         expected_kana.delete();
         fails = 0;
         results = 0;
         pairs = 0;
         empties = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.first = rsp_tdata[15:0];
            got.second = rsp_tdata[31:16];
            got.count = rsp_tdata[33:32];
            if (expected_kana.size() == 0) begin
               $error("Response beat with no prediction waiting: tdata %h", rsp_tdata);
               fails++;
            end else begin
               want = expected_kana.pop_front();
               results++;
               if (want.count == rth_pkg::COUNT_TWO) pairs++;
               if (want.count == rth_pkg::COUNT_NONE) empties++;
               if (got.first !== want.first) begin
                  $error("kana_first: expected %0d, got %0d", want.first, got.first);
                  fails++;
               end
               if (got.second !== want.second) begin
                  $error("kana_second: expected %0d, got %0d", want.second, got.second);
                  fails++;
               end
               if (got.count !== want.count) begin
                  $error("kana_count: expected %0d, got %0d", want.count, got.count);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            ch = req_tdata[rth_pkg::CHAR_W-1:0];
            prior = req_tuser[0] ? '0 : last_char;
            prior2 = req_tuser[0] ? '0 : older_char;
            expected_kana.push_back(predict_kana(ch, prior, prior2));
            older_char = prior;
            last_char = ch;
         end
      end
      fail_count <= fails;
      pending_count <= expected_kana.size();
      result_count <= results;
      pair_count <= pairs;
      empty_count <= empties;
   end

endmodule

// File: tb/romaji_to_hiragana_tail_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// romaji_to_hiragana_tail_test: stream test of the romaji transliterator
// Drives a short directed text through the block, covering the palatal,
// shu, tsu, doubled consonant, syllabic n and punctuation cases, then a
// long random stream of mostly well-formed romaji syllables mixed with
// symbols and arbitrary code points. Both sides idle at random; a separate
// checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
module romaji_to_hiragana_tail_test;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int ONSET_COUNT  = 39;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   int fail_count;
   int pending_count;
   int result_count;
   int pair_count;
   int empty_count;
   int cycle_count = 0;
   int sent_count = 0;
   int start_count = 0;
   bit no_idle = 1'b0;

   string onsets[ONSET_COUNT] = '{"", "k", "s", "t", "n", "h", "m", "y", "r", "w", "g", "z",
                                  "d", "b", "p", "j", "f", "v", "c", "ky", "sh", "ch", "ts",
                                  "ny", "hy", "my", "ry", "gy", "by", "py", "kk", "ss", "tt",
                                  "pp", "sy", "fy", "ty", "hh", "nn"};
   string vowel_letters = "aiueo";

   logic [21:0] directed_text[28] = '{
      {1'b1, 13'd0, "K"}, {1'b0, 13'd0, "y"}, {1'b0, 13'd0, "a"},
      {1'b0, 13'd0, "s"}, {1'b0, 13'd0, "h"}, {1'b0, 13'd0, "u"},
      {1'b0, 13'd0, "t"}, {1'b0, 13'd0, "s"}, {1'b0, 13'd0, "U"},
      {1'b1, 13'd0, "k"}, {1'b0, 13'd0, "k"}, {1'b0, 13'd0, "a"},
      {1'b0, 13'd0, "n"}, {1'b0, 21'd0},      {1'b0, 13'd0, "j"},
      {1'b0, 13'd0, "o"}, {1'b0, 13'd0, "x"}, {1'b0, 13'd0, "e"},
      {1'b0, 13'd0, ","}, {1'b0, 13'd0, "."}, {1'b0, 13'd0, " "},
      {1'b0, 13'd0, "$"}, {1'b0, 13'd0, "-"}, {1'b0, 13'd0, "~"},
      {1'b0, 13'd0, "("}, {1'b0, 13'd0, ")"}, {1'b0, 13'd0, "!"},
      {1'b1, 21'h10FFFF}
   };

   romaji_to_hiragana_tail dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   romaji_to_hiragana_tail_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .pair_count    (pair_count),
      .empty_count   (empty_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_char(input logic [rth_pkg::CHAR_W-1:0] ch, input logic sot);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, ch};
      req_tuser <= sot;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (sot) start_count++;
   endtask

   task automatic send_text(input string text, input logic sot);
      logic [7:0] letter;
      for (int i = 0; i < text.len(); i++) begin
         letter = text.getc(i);
         if (letter >= "a" && letter <= "z" && $urandom_range(0, 3) == 0) begin
            letter = letter - 8'd32;
         end
         send_char({13'd0, letter}, sot && i == 0);
      end
   endtask

   task automatic drain_results;
      do @(posedge clock); while (pending_count != 0);
   endtask

   always begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int  roll;
      int  vowel_pick;
      bit  sot;
      bit  paused;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_text[i]) begin
         send_char(directed_text[i][20:0], directed_text[i][21]);
      end
      req_tvalid <= 1'b0;
      drain_results();

      paused = 1'b0;
      while (sent_count < RANDOM_ITEMS + 28) begin
         if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
         if (!paused && sent_count >= RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            drain_results();
            paused = 1'b1;
         end
         roll = $urandom_range(0, 99);
         sot = ($urandom_range(0, 11) == 0);
         vowel_pick = $urandom_range(0, 4);
         if (roll < 65) begin
            send_text({onsets[$urandom_range(0, ONSET_COUNT - 1)],
                       vowel_letters.substr(vowel_pick, vowel_pick)}, sot);
         end else if (roll < 75) begin
            send_text("n", sot);
            send_char(21'($urandom_range(0, 127)), 1'b0);
         end else if (roll < 85) begin
            send_char(21'($urandom_range(32, 126)), sot);
         end else if (roll < 93) begin
            send_char(21'($urandom_range(0, 127)), sot);
         end else if (roll < 97) begin
            send_char(21'($urandom_range(0, 1114111)), sot);
         end else begin
            send_char(21'($urandom_range(21'h100000, 21'h10FFFF)), sot);
         end
      end
      req_tvalid <= 1'b0;
      drain_results();
      repeat (8) @(posedge clock);

      $display("Sent %0d characters, %0d of them opening a new text.", sent_count, start_count);
      $display("Checked %0d responses: %0d with two kana, %0d with none.",
               result_count, pair_count, empty_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
